>>> design/ljk_pkg.sv
package ljk_pkg;

	localparam int POS_FRAC_BITS_DEF = 16;
	localparam int INT_BITS = 6;
	localparam int BOX_W = 6;
	localparam int KICK_W = 24;
	localparam int AXES = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [BOX_W-1:0] BOX_RESET = 6'd50;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 1'b1;

	// beta^2 in Q32 and the u level where the force reaches its clamp
	localparam logic [31:0] BETA2_Q32 = 32'd18058113;
	localparam logic [31:0] U_CLAMP_P1 = 32'd3619235798;
	localparam logic [30:0] DT_Q40 = 31'd109951163;
	localparam logic [30:0] TEN_DT_Q40 = 31'd1099511628;

	localparam logic [22:0] KICK_MAX = 23'd4294968;
	localparam logic signed [KICK_W-1:0] KICK_POS = 24'sd4294968;
	localparam logic signed [KICK_W-1:0] KICK_NEG = -24'sd4294968;

	// stages per iterative unit
	localparam int LAT_SQ = 32;
	localparam int LAT_U = 32;
	localparam int LAT_M = 40;
	localparam int LAT_R = 33;

endpackage

>>> design/ljk_div.sv
module ljk_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32,
	parameter int QUO_W = 32
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	// One quotient bit per stage. The upper part num >> QUO_W must be below den.
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	logic [DEN_W-1:0] rem_nx [QUO_W];
	logic [DEN_W-1:0] den_nx [QUO_W];
	logic [QUO_W-1:0] low_nx [QUO_W];
	logic [QUO_W-1:0] quo_nx [QUO_W];

	always_comb begin : p_stage
		logic [DEN_W-1:0] prem;
		logic [DEN_W-1:0] pden;
		logic [QUO_W-1:0] plow;
		logic [QUO_W-1:0] pquo;
		logic [DEN_W:0]   cat;
		logic             ge;
		for (int i = 0; i < QUO_W; i++) begin
			if (i == 0) begin
				prem = DEN_W'(num >> QUO_W);
				pden = den;
				plow = num[QUO_W-1:0];
				pquo = '0;
			end else begin
				prem = rem_s[i-1];
				pden = den_s[i-1];
				plow = low_s[i-1];
				pquo = quo_s[i-1];
			end
			cat = {prem, plow[QUO_W-1]};
			ge = (cat >= {1'b0, pden});
			rem_nx[i] = ge ? DEN_W'(cat - {1'b0, pden}) : cat[DEN_W-1:0];
			den_nx[i] = pden;
			low_nx[i] = plow << 1;
			quo_nx[i] = {pquo[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUO_W; i++) begin
			rem_s[i] <= rem_nx[i];
			den_s[i] <= den_nx[i];
			low_s[i] <= low_nx[i];
			quo_s[i] <= quo_nx[i];
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

>>> design/lj_pair_velocity_kick_top.sv
// Lennard-Jones pair kick, minimum image in a periodic 2-D box. One pair may be
// started in every cycle (busy stays low); its result appears with done high for
// a single cycle, and results leave in start order. The pipeline depth is set
// by the chain of bit-per-stage units: five front-end stages, a 32-stage divider
// for beta^2/r^2 followed by six stages of multiplies, a 40-stage divider for the
// force component and two output stages; a 32-stage root and 33-stage divider
// for the near-range ratio run alongside.
// Results cannot be held off: take them in the cycle that done is high.
// Box registers are written through cfg_we/cfg_index/cfg_data and take effect
// for pairs started afterwards.
module lj_pair_velocity_kick_top import ljk_pkg::*; #(
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [INT_BITS+POS_FRAC_BITS-1:0] own_x,
	input  logic [INT_BITS+POS_FRAC_BITS-1:0] own_y,
	input  logic [INT_BITS+POS_FRAC_BITS-1:0] other_x,
	input  logic [INT_BITS+POS_FRAC_BITS-1:0] other_y,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [BOX_W-1:0]              cfg_data,
	output logic                          done,
	output logic signed [KICK_W-1:0]      kick_vx,
	output logic signed [KICK_W-1:0]      kick_vy,
	output logic                          coincident
);

	localparam int POS_W = INT_BITS + POS_FRAC_BITS;
	localparam int EW = POS_W + 2;
	localparam int AW = POS_W + 1;
	localparam int LW = POS_FRAC_BITS;
	localparam int D2W = 2 * LW + 1;
	localparam int SQ_RW = 34;

	localparam int ST_ROOT = 5 + LAT_SQ;
	localparam int ST_U = 5 + LAT_U;
	localparam int ST_PROD = ST_U + 6;
	localparam int ST_M = ST_PROD + LAT_M;
	localparam int ST_RATIO = ST_ROOT + LAT_R;
	localparam int LATENCY = ST_M + 2;

	localparam int AX_LEN = ST_PROD - 6;
	localparam int S32_LEN = ST_PROD - 5;
	localparam int CTL_LEN = ST_M - 7;
	localparam int GN_LEN = ST_M - ST_PROD;
	localparam int RAT_LEN = ST_M - ST_RATIO;

	typedef struct packed {
		logic            valid;
		logic            coinc;
		logic            far;
		logic            clamp;
		logic [AXES-1:0] neg;
	} ctrl_t;

	logic [BOX_W-1:0] box_width_q, box_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_width_q  <= BOX_RESET;
			box_height_q <= BOX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_WIDTH:  box_width_q <= cfg_data;
				REG_BOX_HEIGHT: box_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	function automatic logic signed [EW-1:0] wrap_axis(input logic signed [EW-1:0] e,
			input logic [BOX_W-1:0] box);
		logic signed [EW-1:0] span;
		logic signed [EW-1:0] half;
		logic signed [EW-1:0] r;
		span = $signed(EW'(box) << POS_FRAC_BITS);
		half = $signed(EW'(box >> 1) << POS_FRAC_BITS);
		r = e;
		if (r > half) r = r - span;
		if (r < -half) r = r + span;
		return r;
	endfunction

	// front end
	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [EW-1:0] e_s1 [AXES];
	logic signed [EW-1:0] e_s2 [AXES];
	logic [AW-1:0]        a_s3 [AXES];
	logic [AXES-1:0]      neg_s3, neg_s4;
	logic [LW-1:0]        alo_s4 [AXES];
	logic                 big_s4, zero_s4;
	logic [D2W-1:0]       d2_s4;
	ctrl_t                ctrl_s5, ctrl_s6, ctrl_s7;
	logic [31:0]          s32_s5;
	logic [63:0]          arg_s5;
	logic [23:0]          a24_s5 [AXES];
	logic [63:0]          cprod_s6;
	logic                 s32z_s6;

	// delay lines
	ctrl_t       ctrl_dly [CTL_LEN];
	logic [23:0] a24_dly [AXES][AX_LEN];
	logic [31:0] s32_dly [S32_LEN];
	logic        gneg_dly [AXES][GN_LEN];
	logic [32:0] ratio_dly [AXES][RAT_LEN];

	// square root
	logic [SQ_RW-1:0] sq_rem_s [LAT_SQ];
	logic [31:0]      sq_root_s [LAT_SQ];
	logic [63:0]      sq_arg_s [LAT_SQ];
	logic [SQ_RW-1:0] sq_rem_nx [LAT_SQ];
	logic [31:0]      sq_root_nx [LAT_SQ];
	logic [63:0]      sq_arg_nx [LAT_SQ];
	logic [31:0]      root_fix;

	// force chain
	logic [31:0] u_s37;
	logic [31:0] u_s38, u2_s38, w_s39, w_s40;
	logic [32:0] p_s40, t_s41;
	logic        gneg_s40, gneg_s41, gneg_s42;
	logic [35:0] g_s42;
	logic [59:0] prod_s43 [AXES];
	logic        gneg_s43 [AXES];
	logic [63:0] ratio_num [AXES];
	logic [63:0] m_num [AXES];
	logic [32:0] ratio_s70 [AXES];
	logic [39:0] m_s83 [AXES];

	// back end
	ctrl_t       ctrl_s83, ctrl_s84;
	logic [67:0] prod_nx [AXES];
	logic [67:0] prod_s84 [AXES];
	logic [AXES-1:0] neg_nx, neg_s84;
	logic [KICK_W-1:0] kick_nx [AXES];
	logic [KICK_W-1:0] kick_s85 [AXES];
	logic        done_s85, coinc_s85;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			ctrl_s5  <= '0;
			ctrl_s6  <= '0;
			ctrl_s7  <= '0;
			for (int i = 0; i < CTL_LEN; i++) ctrl_dly[i] <= '0;
			ctrl_s84 <= '0;
			done_s85 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			ctrl_s5.valid <= valid_s4;
			ctrl_s5.coinc <= zero_s4;
			ctrl_s5.far   <= big_s4 || d2_s4[D2W-1];
			ctrl_s5.clamp <= 1'b0;
			ctrl_s5.neg   <= neg_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= {ctrl_s6.valid, ctrl_s6.coinc, ctrl_s6.far,
				s32z_s6 || ({BETA2_Q32, 32'b0} >= cprod_s6), ctrl_s6.neg};
			ctrl_dly[0] <= ctrl_s7;
			for (int i = 1; i < CTL_LEN; i++) ctrl_dly[i] <= ctrl_dly[i-1];
			ctrl_s84 <= ctrl_s83;
			done_s85 <= ctrl_s84.valid;
		end
	end

	assign ctrl_s83 = ctrl_dly[CTL_LEN-1];

	always_ff @(posedge clk) begin
		e_s1[0] <= $signed(EW'(own_x) - EW'(other_x));
		e_s1[1] <= $signed(EW'(own_y) - EW'(other_y));
		e_s2[0] <= wrap_axis(e_s1[0], box_width_q);
		e_s2[1] <= wrap_axis(e_s1[1], box_height_q);
		for (int l = 0; l < AXES; l++) begin
			neg_s3[l] <= e_s2[l] < 0;
			a_s3[l]   <= AW'((e_s2[l] < 0) ? -e_s2[l] : e_s2[l]);
			alo_s4[l] <= a_s3[l][LW-1:0];
			a24_s5[l] <= 24'(alo_s4[l]) << (24 - LW);
		end
		neg_s4  <= neg_s3;
		big_s4  <= (|a_s3[0][AW-1:LW]) || (|a_s3[1][AW-1:LW]);
		zero_s4 <= (a_s3[0] == '0) && (a_s3[1] == '0);
		d2_s4   <= D2W'(a_s3[0][LW-1:0]) * D2W'(a_s3[0][LW-1:0])
			+ D2W'(a_s3[1][LW-1:0]) * D2W'(a_s3[1][LW-1:0]);
		// bring r^2 to Q32 and scale the root argument so the root is r in Q34
		s32_s5   <= 32'((64'(d2_s4[2*LW-1:0]) << (48 - 2 * LW)) >> 16);
		arg_s5   <= 64'(d2_s4) << (68 - 2 * LW);
		cprod_s6 <= 64'(s32_s5) * 64'(U_CLAMP_P1);
		s32z_s6  <= (s32_s5 == '0);

		s32_dly[0] <= s32_s5;
		for (int i = 1; i < S32_LEN; i++) s32_dly[i] <= s32_dly[i-1];
		for (int l = 0; l < AXES; l++) begin
			a24_dly[l][0] <= a24_s5[l];
			for (int i = 1; i < AX_LEN; i++) a24_dly[l][i] <= a24_dly[l][i-1];
			gneg_dly[l][0] <= gneg_s43[l];
			for (int i = 1; i < GN_LEN; i++) gneg_dly[l][i] <= gneg_dly[l][i-1];
			ratio_dly[l][0] <= ratio_s70[l];
			for (int i = 1; i < RAT_LEN; i++) ratio_dly[l][i] <= ratio_dly[l][i-1];
		end

		u_s38    <= u_s37;
		u2_s38   <= 32'((64'(u_s37) * 64'(u_s37)) >> 32);
		w_s39    <= 32'((64'(u2_s38) * 64'(u_s38)) >> 32);
		w_s40    <= w_s39;
		gneg_s40 <= ({w_s39, 1'b0} < 33'h1_0000_0000);
		p_s40    <= ({w_s39, 1'b0} < 33'h1_0000_0000) ? 33'h1_0000_0000 - {w_s39, 1'b0}
			: {w_s39, 1'b0} - 33'h1_0000_0000;
		t_s41    <= 33'((65'(w_s40) * 65'(p_s40)) >> 32);
		gneg_s41 <= gneg_s40;
		g_s42    <= 36'({t_s41, 2'b00}) + 36'({t_s41, 1'b0});
		gneg_s42 <= gneg_s41;
		for (int l = 0; l < AXES; l++) begin
			prod_s43[l] <= 60'(g_s42) * 60'(a24_dly[l][ST_PROD-7]);
			gneg_s43[l] <= gneg_s42;
			prod_s84[l] <= prod_nx[l];
			kick_s85[l] <= kick_nx[l];
		end
		neg_s84   <= neg_nx;
		coinc_s85 <= ctrl_s84.coinc;
	end

	// square root, two argument bits per stage
	always_comb begin : p_sqrt
		logic [SQ_RW-1:0] prem;
		logic [31:0]      proot;
		logic [63:0]      parg;
		logic [SQ_RW+1:0] acc;
		logic [SQ_RW+1:0] tsub;
		logic             ge;
		for (int i = 0; i < LAT_SQ; i++) begin
			if (i == 0) begin
				prem  = '0;
				proot = '0;
				parg  = arg_s5;
			end else begin
				prem  = sq_rem_s[i-1];
				proot = sq_root_s[i-1];
				parg  = sq_arg_s[i-1];
			end
			acc  = {prem, parg[63:62]};
			tsub = {2'b00, proot, 2'b01};
			ge   = (acc >= tsub);
			sq_rem_nx[i]  = ge ? SQ_RW'(acc - tsub) : SQ_RW'(acc);
			sq_root_nx[i] = {proot[30:0], ge};
			sq_arg_nx[i]  = {parg[61:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LAT_SQ; i++) begin
			sq_rem_s[i]  <= sq_rem_nx[i];
			sq_root_s[i] <= sq_root_nx[i];
			sq_arg_s[i]  <= sq_arg_nx[i];
		end
	end

	assign root_fix = (sq_root_s[LAT_SQ-1] == '0) ? 32'd1 : sq_root_s[LAT_SQ-1];

	ljk_div #(.NUM_W(64), .DEN_W(32), .QUO_W(LAT_U)) u_div_u (
		.clk (clk),
		.num ({BETA2_Q32, 32'b0}),
		.den (s32_s5),
		.quo (u_s37)
	);

	for (genvar l = 0; l < AXES; l++) begin : g_lane
		assign ratio_num[l] = 64'({a24_dly[l][ST_ROOT-6], 42'b0});
		assign m_num[l] = {prod_s43[l][55:0], 8'b0};

		ljk_div #(.NUM_W(64), .DEN_W(32), .QUO_W(LAT_R)) u_div_ratio (
			.clk (clk),
			.num (ratio_num[l]),
			.den (root_fix),
			.quo (ratio_s70[l])
		);

		ljk_div #(.NUM_W(64), .DEN_W(32), .QUO_W(LAT_M)) u_div_m (
			.clk (clk),
			.num (m_num[l]),
			.den (s32_dly[S32_LEN-1]),
			.quo (m_s83[l])
		);
	end

	// pick the clamped or the full-force magnitude and scale by the time step
	always_comb begin : p_scale
		logic [32:0] rat;
		logic [32:0] rmin;
		logic [36:0] msel;
		logic [30:0] ksel;
		for (int l = 0; l < AXES; l++) begin
			rat  = ratio_dly[l][RAT_LEN-1];
			rmin = (rat > 33'h1_0000_0000) ? 33'h1_0000_0000 : rat;
			msel = ctrl_s83.clamp ? 37'(rmin) : m_s83[l][36:0];
			ksel = ctrl_s83.clamp ? TEN_DT_Q40 : DT_Q40;
			prod_nx[l] = 68'(msel) * 68'(ksel) + (68'(1) << 39);
			neg_nx[l]  = ctrl_s83.neg[l] ^ (!ctrl_s83.clamp && gneg_dly[l][GN_LEN-1]);
		end
	end

	// round, saturate, apply sign; drop to zero for coincident or far pairs
	always_comb begin : p_field
		logic [27:0] mag;
		logic [22:0] sat;
		for (int l = 0; l < AXES; l++) begin
			mag = prod_s84[l][67:40];
			sat = (mag > 28'(KICK_MAX)) ? KICK_MAX : mag[22:0];
			if (ctrl_s84.coinc || ctrl_s84.far) kick_nx[l] = '0;
			else if (neg_s84[l]) kick_nx[l] = -{1'b0, sat};
			else kick_nx[l] = {1'b0, sat};
		end
	end

	assign done       = done_s85;
	assign kick_vx    = $signed(kick_s85[0]);
	assign kick_vy    = $signed(kick_s85[1]);
	assign coincident = done_s85 && coinc_s85;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("started pair did not complete on time");

	a_coinc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && coincident |-> kick_vx == '0 && kick_vy == '0)
		else $error("coincident pair with nonzero kick");

	a_far_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s84.valid && ctrl_s84.far |=> done && !coincident && kick_vx == '0 && kick_vy == '0)
		else $error("far pair with nonzero kick");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> kick_vx <= KICK_POS && kick_vx >= KICK_NEG &&
			kick_vy <= KICK_POS && kick_vy >= KICK_NEG)
		else $error("kick beyond saturation limit");

endmodule
